FILE: src/stim_pulse_train_sequencer_macros.svh
// Assertion macros used by the sequencer's top-level RTL file.
`ifndef STIM_PULSE_TRAIN_SEQUENCER_MACROS_SVH
`define STIM_PULSE_TRAIN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STPTS_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/stpts_pkg.sv
`default_nettype none

package stpts_pkg;

    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_NUM_ENTRIES  = 3'd0,
        REG_NUM_CYCLES   = 3'd1,
        REG_STIM_IVL     = 3'd2,
        REG_PULSE_ON     = 3'd3,
        REG_PULSE_OFF    = 3'd4,
        REG_PARAMS_READY = 3'd5
    } reg_idx_t;

    localparam logic [4:0]  NUM_ENTRIES_RST = 5'd0;
    localparam logic [15:0] NUM_CYCLES_RST  = 16'd20;
    localparam logic [23:0] STIM_IVL_RST    = 24'd5000;
    localparam logic [15:0] PULSE_ON_RST    = 16'd50;
    localparam logic [15:0] PULSE_OFF_RST   = 16'd50;

    typedef struct packed {
        logic [4:0]  num_entries_used;
        logic [15:0] num_cycles;
        logic [23:0] stim_interval_ms;
        logic [15:0] pulse_on_ms;
        logic [15:0] pulse_off_ms;
        logic        params_ready;
    } cfg_t;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  entry_index;
        logic [15:0] entry_value;
    } item_t;

    typedef struct packed {
        logic        laser_on;
        logic        running;
        logic        sequence_done;
        logic [3:0]  entry_now;
        logic [15:0] cycle_now;
    } result_t;

endpackage

`default_nettype wire

FILE: src/stpts_cfg.sv
`default_nettype none

module stpts_cfg
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [stpts_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output stpts_pkg::cfg_t                cfg
);
    import stpts_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_entries_used <= NUM_ENTRIES_RST;
            cfg_reg.num_cycles       <= NUM_CYCLES_RST;
            cfg_reg.stim_interval_ms <= STIM_IVL_RST;
            cfg_reg.pulse_on_ms      <= PULSE_ON_RST;
            cfg_reg.pulse_off_ms     <= PULSE_OFF_RST;
            cfg_reg.params_ready     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_NUM_ENTRIES:  cfg_reg.num_entries_used <= pwdata[4:0];
                REG_NUM_CYCLES:   cfg_reg.num_cycles       <= pwdata[15:0];
                REG_STIM_IVL:     cfg_reg.stim_interval_ms <= pwdata[23:0];
                REG_PULSE_ON:     cfg_reg.pulse_on_ms      <= pwdata[15:0];
                REG_PULSE_OFF:    cfg_reg.pulse_off_ms     <= pwdata[15:0];
                REG_PARAMS_READY: cfg_reg.params_ready     <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_ENTRIES:  prdata = {27'd0, cfg_reg.num_entries_used};
            REG_NUM_CYCLES:   prdata = {16'd0, cfg_reg.num_cycles};
            REG_STIM_IVL:     prdata = {8'd0, cfg_reg.stim_interval_ms};
            REG_PULSE_ON:     prdata = {16'd0, cfg_reg.pulse_on_ms};
            REG_PULSE_OFF:    prdata = {16'd0, cfg_reg.pulse_off_ms};
            REG_PARAMS_READY: prdata = {31'd0, cfg_reg.params_ready};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/stpts_seq.sv
`default_nettype none

module stpts_seq
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  stpts_pkg::item_t       item,
    input  stpts_pkg::cfg_t        cfg,
    output stpts_pkg::result_t     result
);
    import stpts_pkg::*;

    // Only the first sixteen slots can ever be loaded; the rest are never written.
    localparam int STORE_DEPTH = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
    localparam int CNT_MAX     = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
    localparam int SW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PTR_W       = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        logic [15:0]      cyc;
        logic             done;
    } fin_t;

    logic [15:0]      store_mem [STORE_DEPTH];
    logic             zero_flag [STORE_DEPTH];

    logic             active_reg, active_next;
    logic [23:0]      ivl_tmr_reg, ivl_tmr_next;
    logic             stim_reg, stim_next;
    logic [15:0]      stim_tmr_reg, stim_tmr_next;
    logic             gate_reg, gate_next;
    logic [15:0]      gate_tmr_reg, gate_tmr_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [15:0]      cyc_reg, cyc_next;

    logic [4:0]       entry_cnt;
    logic [15:0]      dur_cur;
    logic             done;
    fin_t             fin_a, fin_b;
    logic             load_ok;

    // Advances the entry pointer past a finished stimulus and closes the pass at the end.
    function automatic fin_t finish(input logic [PTR_W-1:0] ptr, input logic [15:0] cyc,
                                    input logic [4:0] cnt, input logic [15:0] ncyc);
        fin_t       f;
        logic [5:0] inc;
        inc    = 6'(ptr) + 6'd1;
        f.ptr  = PTR_W'(inc);
        f.cyc  = cyc;
        f.done = 1'b0;
        if (inc >= {1'b0, cnt})
        begin
            f.ptr  = '0;
            f.cyc  = (cyc == 16'hFFFF) ? cyc : cyc + 16'd1;
            f.done = (f.cyc >= ncyc);
        end
        return f;
    endfunction

    assign entry_cnt = (32'(cfg.num_entries_used) > TABLE_DEPTH) ?
                       5'(TABLE_DEPTH) : cfg.num_entries_used;
    assign dur_cur   = store_mem[ptr_reg[SW-1:0]];
    assign load_ok   = (32'(item.entry_index) < TABLE_DEPTH);

    always_comb
    begin
        active_next   = active_reg;
        ivl_tmr_next  = ivl_tmr_reg;
        stim_next     = stim_reg;
        stim_tmr_next = stim_tmr_reg;
        gate_next     = gate_reg;
        gate_tmr_next = gate_tmr_reg;
        ptr_next      = ptr_reg;
        cyc_next      = cyc_reg;
        done          = 1'b0;
        fin_a         = finish(ptr_reg, cyc_reg, entry_cnt, cfg.num_cycles);
        fin_b         = '0;

        unique case (item.command)
            CMD_TICK:
            begin
                if (active_reg)
                begin
                    ivl_tmr_next = (ivl_tmr_reg == 24'hFFFFFF) ? ivl_tmr_reg
                                                               : ivl_tmr_reg + 24'd1;
                    if (stim_reg)
                    begin
                        stim_tmr_next = (stim_tmr_reg == 16'hFFFF) ? stim_tmr_reg
                                                                   : stim_tmr_reg + 16'd1;
                        gate_tmr_next = (gate_tmr_reg == 16'hFFFF) ? gate_tmr_reg
                                                                   : gate_tmr_reg + 16'd1;
                        if (stim_tmr_next >= dur_cur)
                        begin
                            stim_next   = 1'b0;
                            gate_next   = 1'b0;
                            ptr_next    = fin_a.ptr;
                            cyc_next    = fin_a.cyc;
                            done        = fin_a.done;
                            active_next = !fin_a.done;
                        end
                        else if (cfg.pulse_off_ms != 16'd0)
                        begin
                            if (gate_reg && gate_tmr_next >= cfg.pulse_on_ms)
                            begin
                                gate_next     = 1'b0;
                                gate_tmr_next = 16'd0;
                            end
                            else if (!gate_reg && gate_tmr_next >= cfg.pulse_off_ms)
                            begin
                                gate_next     = 1'b1;
                                gate_tmr_next = 16'd0;
                            end
                        end
                    end

                    fin_b = finish(ptr_next, cyc_next, entry_cnt, cfg.num_cycles);
                    if (active_next && !stim_next &&
                        ivl_tmr_next >= cfg.stim_interval_ms &&
                        6'(ptr_next) < {1'b0, entry_cnt})
                    begin
                        ivl_tmr_next  = 24'd0;
                        stim_tmr_next = 16'd0;
                        gate_tmr_next = 16'd0;
                        gate_next     = 1'b1;
                        stim_next     = 1'b1;
                        // A zero-length stimulus ends in the same tick that starts it.
                        if (zero_flag[ptr_next[SW-1:0]])
                        begin
                            stim_next   = 1'b0;
                            gate_next   = 1'b0;
                            ptr_next    = fin_b.ptr;
                            cyc_next    = fin_b.cyc;
                            done        = fin_b.done;
                            active_next = !fin_b.done;
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (cfg.params_ready)
                begin
                    active_next   = 1'b1;
                    cyc_next      = 16'd0;
                    ptr_next      = '0;
                    ivl_tmr_next  = 24'd0;
                    stim_next     = 1'b0;
                    stim_tmr_next = 16'd0;
                    gate_next     = 1'b0;
                    gate_tmr_next = 16'd0;
                end
            end
            CMD_STOP:
            begin
                active_next = 1'b0;
                stim_next   = 1'b0;
                gate_next   = 1'b0;
            end
            CMD_LOAD:
            begin
            end
            default:
            begin
            end
        endcase

        result.laser_on      = stim_next && (gate_next || cfg.pulse_off_ms == 16'd0);
        result.running       = active_next;
        result.sequence_done = done;
        result.entry_now     = 4'(ptr_next);
        result.cycle_now     = cyc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            ivl_tmr_reg  <= 24'd0;
            stim_reg     <= 1'b0;
            stim_tmr_reg <= 16'd0;
            gate_reg     <= 1'b0;
            gate_tmr_reg <= 16'd0;
            ptr_reg      <= '0;
            cyc_reg      <= 16'd0;
        end
        else if (step)
        begin
            active_reg   <= active_next;
            ivl_tmr_reg  <= ivl_tmr_next;
            stim_reg     <= stim_next;
            stim_tmr_reg <= stim_tmr_next;
            gate_reg     <= gate_next;
            gate_tmr_reg <= gate_tmr_next;
            ptr_reg      <= ptr_next;
            cyc_reg      <= cyc_next;
        end
    end

    // The duration table has no reset; a zero flag per slot is kept beside it.
    always_ff @(posedge clk)
    begin
        if (step && item.command == CMD_LOAD && load_ok)
        begin
            store_mem[item.entry_index[SW-1:0]] <= item.entry_value;
            zero_flag[item.entry_index[SW-1:0]] <= (item.entry_value == 16'd0);
        end
    end

endmodule

`default_nettype wire

FILE: src/stim_pulse_train_sequencer.sv
// Pipeline: a transaction is captured in the input register, and its result in the
// result register.
// Throughput: one transaction per clock while m_tready is high; the result register
// and the input register each take a new transaction whenever the next stage is free.
// Reset: rst_n clears the sequencer state and loads the register defaults at once;
// the duration table holds no value until it is loaded.
`default_nettype none

`include "stim_pulse_train_sequencer_macros.svh"

module stim_pulse_train_sequencer
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,  // entry_index[3:0], entry_value[19:4]
    input  wire logic [1:0]                   s_tuser,  // command[1:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [23:0]                  m_tdata,  // laser_on[0], running[1],
                                                        // entry_now[5:2], cycle_now[21:6]
    output logic                              m_tlast,  // sequence_done
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stpts_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import stpts_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t seq_result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    step;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    stpts_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stpts_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.command     <= cmd_t'(s_tuser);
            in_item_reg.entry_index <= s_tdata[3:0];
            in_item_reg.entry_value <= s_tdata[19:4];
        end
        if (step)
        begin
            out_result_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_result_reg.sequence_done;
    assign m_tdata  = {2'b00, out_result_reg.cycle_now, out_result_reg.entry_now,
                       out_result_reg.running, out_result_reg.laser_on};

    `STPTS_ASSERT(a_laser_only_running, clk, rst_n, out_valid_reg && out_result_reg.laser_on, out_result_reg.running, "laser on while the sequence is idle")
    `STPTS_ASSERT(a_done_stops_run, clk, rst_n, out_valid_reg && out_result_reg.sequence_done, !out_result_reg.running, "sequence done while still running")
    `STPTS_ASSERT(a_stall_only_when_full, clk, rst_n, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled with room downstream")
    `STPTS_ASSERT_NEXT(a_result_drains, clk, rst_n, out_valid_reg && m_tready && !step, !out_valid_reg, "result register not emptied after its transaction")

endmodule

`default_nettype wire
